>>> sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers shared by the rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, off during reset
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed: implication");

// next-cycle implication, off during reset
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons)

`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

>>> sv/emb3_pkg.sv
// ----------------------------------------------------------------------------
// emb3_pkg
// widths, register indexes and reset values of the 3x3 emboss filter
// ----------------------------------------------------------------------------
package emb3_pkg;

    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 1024;

    localparam int PIX_W       = 8;
    localparam int SIZE_W      = 11;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 11;
    // right + up - left - down, negated, plus brightness fits in 11 signed bits
    localparam int SUM_W       = PIX_W + 3;

    localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MODE       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BRIGHTNESS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH      = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT     = 2'd3;

    localparam logic [SIZE_W-1:0] WIDTH_RST  = 11'd1024;
    localparam logic [SIZE_W-1:0] HEIGHT_RST = 11'd1024;

    // request opcodes
    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    // kernel select
    localparam logic MODE_INDENT  = 1'b0;
    localparam logic MODE_EXTRUDE = 1'b1;

endpackage

>>> sv/emboss_filter_3x3_unit.sv
// ----------------------------------------------------------------------------
// emboss_filter_3x3_unit
// streaming 3x3 emboss on 8-bit samples, results one row behind the input
// ----------------------------------------------------------------------------
// Accepts one request per clock and returns one result per clock once the
// second row of a frame is arriving; a result reaches the output register by
// way of the first-stage registers that hold its request. The first stage
// registers the request together with the row buffer reads (current row at
// column c and c+1, previous row at column c); the second stage forms
// right + up - left - down, applies mode and brightness, saturates and writes
// the row buffers back. A write from the request ahead is forwarded into the
// reads, so widths down to one pixel run at full rate. The row buffers are
// two MAX_WIDTH x 8 RAMs with no clearing pass: neighbors outside the image
// are masked to zero. Only a stalled result register holds up the input.
// After the last row, send width flush requests to drain the final row;
// flush requests during the frame are dropped.
// ----------------------------------------------------------------------------
module emboss_filter_3x3_unit #(
    parameter int MAX_WIDTH  = emb3_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = emb3_pkg::MAX_HEIGHT_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,

    input  logic                             cfg_wr_en,
    input  logic [emb3_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [emb3_pkg::CFG_DATA_W-1:0]  cfg_data,

    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic                             s_op,
    input  logic [emb3_pkg::PIX_W-1:0]       s_sample,

    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [emb3_pkg::PIX_W-1:0]       m_pixel,
    output logic                             m_row_end,
    output logic                             m_frame_end
);

    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int RW   = $clog2(MAX_HEIGHT + 1);
    localparam int WSZ  = ($clog2(MAX_WIDTH + 1) > emb3_pkg::SIZE_W) ?
                          $clog2(MAX_WIDTH + 1) : emb3_pkg::SIZE_W;
    localparam int HSZ  = (RW > emb3_pkg::SIZE_W) ? RW : emb3_pkg::SIZE_W;
    localparam int PW   = emb3_pkg::PIX_W;
    localparam int SW   = emb3_pkg::SUM_W;

    // configuration
    logic                       mode_reg;
    logic [PW-1:0]              brightness_reg;
    logic [emb3_pkg::SIZE_W-1:0] width_reg;
    logic [emb3_pkg::SIZE_W-1:0] height_reg;

    // raster position
    logic [CW-1:0]              col_cnt_reg;
    logic [RW-1:0]              row_cnt_reg;

    // first stage
    logic                       s1_valid_reg;
    logic [CW-1:0]              s1_col_reg;
    logic [PW-1:0]              s1_down_reg;
    logic                       s1_up_en_reg;
    logic                       s1_left_en_reg;
    logic                       s1_right_en_reg;
    logic                       s1_last_col_reg;
    logic                       s1_frame_end_reg;
    logic                       s1_emit_reg;

    // row buffers and their read data
    logic [PW-1:0]              cur_mem  [MAX_WIDTH];
    logic [PW-1:0]              prev_mem [MAX_WIDTH];
    logic [PW-1:0]              cur_rd0_reg;
    logic [PW-1:0]              cur_rd1_reg;
    logic [PW-1:0]              prev_rd_reg;
    logic                       fwd0_reg;
    logic                       fwd1_reg;
    logic [PW-1:0]              fwd_cur_reg;
    logic [PW-1:0]              fwd_prev_reg;
    logic [PW-1:0]              left_hold_reg;

    // result register
    logic                       m_valid_reg;
    logic [PW-1:0]              m_pixel_reg;
    logic                       m_row_end_reg;
    logic                       m_frame_end_reg;

    // request side
    logic [WSZ-1:0]             w_eff;
    logic [HSZ-1:0]             h_eff;
    logic                       flushing;
    logic                       accept;
    logic                       skip;
    logic                       work;
    logic                       right_en;
    logic [CW-1:0]              col_plus1;
    logic [CW-1:0]              col_cnt_next;
    logic [RW-1:0]              row_cnt_next;

    // second stage
    logic                       s1_advance;
    logic [PW-1:0]              old_val;
    logic [PW-1:0]              up_v;
    logic [PW-1:0]              left_v;
    logic [PW-1:0]              right_v;
    logic signed [SW-1:0]       sum_k;
    logic signed [SW-1:0]       sum_m;
    logic signed [SW-1:0]       sum_b;
    logic [PW-1:0]              pixel_next;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg       <= emb3_pkg::MODE_INDENT;
            brightness_reg <= '0;
            width_reg      <= emb3_pkg::WIDTH_RST;
            height_reg     <= emb3_pkg::HEIGHT_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                emb3_pkg::REG_MODE:       mode_reg       <= cfg_data[0];
                emb3_pkg::REG_BRIGHTNESS: brightness_reg <= cfg_data[PW-1:0];
                emb3_pkg::REG_WIDTH:      width_reg      <= cfg_data[emb3_pkg::SIZE_W-1:0];
                emb3_pkg::REG_HEIGHT:     height_reg     <= cfg_data[emb3_pkg::SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    // zero counts as one, oversize saturates to the maximum
    always_comb begin
        priority if (width_reg == '0) begin
            w_eff = WSZ'(1);
        end else if (WSZ'(width_reg) > WSZ'(MAX_WIDTH)) begin
            w_eff = WSZ'(MAX_WIDTH);
        end else begin
            w_eff = WSZ'(width_reg);
        end
        priority if (height_reg == '0) begin
            h_eff = HSZ'(1);
        end else if (HSZ'(height_reg) > HSZ'(MAX_HEIGHT)) begin
            h_eff = HSZ'(MAX_HEIGHT);
        end else begin
            h_eff = HSZ'(height_reg);
        end
    end

    // ------------------------------------------------------------------
    // request acceptance and raster counters
    // ------------------------------------------------------------------
    assign s1_advance = s1_valid_reg && (!s1_emit_reg || !m_valid_reg || m_ready);
    assign s_ready    = !s1_valid_reg || s1_advance;
    assign accept     = s_valid && s_ready;
    assign flushing   = HSZ'(row_cnt_reg) >= h_eff;
    // a flush request before the last row has been fully received has no effect
    assign skip       = (s_op == emb3_pkg::OP_FLUSH) && !flushing;
    assign work       = accept && !skip;
    assign right_en   = (WSZ'(col_cnt_reg) + WSZ'(1)) < w_eff;
    assign col_plus1  = col_cnt_reg + CW'(1);

    always_comb begin
        col_cnt_next = col_plus1;
        row_cnt_next = row_cnt_reg;
        if (!right_en) begin
            col_cnt_next = '0;
            row_cnt_next = flushing ? '0 : row_cnt_reg + RW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_cnt_reg <= '0;
            row_cnt_reg <= '0;
        end else if (work) begin
            col_cnt_reg <= col_cnt_next;
            row_cnt_reg <= row_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (work) begin
            s1_valid_reg <= 1'b1;
        end else if (s1_advance) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (work) begin
            s1_col_reg       <= col_cnt_reg;
            s1_down_reg      <= flushing ? '0 : s_sample;
            s1_up_en_reg     <= row_cnt_reg >= RW'(2);
            s1_left_en_reg   <= col_cnt_reg != '0;
            s1_right_en_reg  <= right_en;
            s1_last_col_reg  <= !right_en;
            s1_frame_end_reg <= !right_en && flushing;
            s1_emit_reg      <= row_cnt_reg != '0;
        end
    end

    // ------------------------------------------------------------------
    // row buffers: write from the second stage, read for the new request
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (s1_advance) begin
            cur_mem[s1_col_reg]  <= s1_down_reg;
            prev_mem[s1_col_reg] <= old_val;
        end
        if (work) begin
            cur_rd0_reg  <= cur_mem[col_cnt_reg];
            cur_rd1_reg  <= cur_mem[col_plus1];
            prev_rd_reg  <= prev_mem[col_cnt_reg];
            // the write at this same edge is not seen by the read above
            fwd0_reg     <= s1_advance && (s1_col_reg == col_cnt_reg);
            fwd1_reg     <= s1_advance && (s1_col_reg == col_plus1);
            fwd_cur_reg  <= s1_down_reg;
            fwd_prev_reg <= old_val;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_advance) begin
            left_hold_reg <= old_val;
        end
    end

    // ------------------------------------------------------------------
    // kernel, brightness and saturation
    // ------------------------------------------------------------------
    assign old_val = fwd0_reg ? fwd_cur_reg : cur_rd0_reg;
    assign up_v    = !s1_up_en_reg    ? '0 : (fwd0_reg ? fwd_prev_reg : prev_rd_reg);
    assign right_v = !s1_right_en_reg ? '0 : (fwd1_reg ? fwd_cur_reg : cur_rd1_reg);
    assign left_v  = s1_left_en_reg ? left_hold_reg : '0;

    always_comb begin
        sum_k = $signed(SW'(right_v)) + $signed(SW'(up_v))
              - $signed(SW'(left_v)) - $signed(SW'(s1_down_reg));
        sum_m = (mode_reg == emb3_pkg::MODE_EXTRUDE) ? -sum_k : sum_k;
        sum_b = sum_m + $signed(SW'(brightness_reg));
        priority if (sum_b < $signed(SW'(0))) begin
            pixel_next = '0;
        end else if (sum_b > $signed(SW'(emb3_pkg::PIX_MAX))) begin
            pixel_next = emb3_pkg::PIX_MAX;
        end else begin
            pixel_next = sum_b[PW-1:0];
        end
    end

    // ------------------------------------------------------------------
    // result register
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s1_advance && s1_emit_reg) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_advance && s1_emit_reg) begin
            m_pixel_reg     <= pixel_next;
            m_row_end_reg   <= s1_last_col_reg;
            m_frame_end_reg <= s1_frame_end_reg;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_pixel     = m_pixel_reg;
    assign m_row_end   = m_row_end_reg;
    assign m_frame_end = m_frame_end_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
`include "assert_macros.svh"

    `ASSERT_IMPLIES(a_frame_end_on_row_end, aclk, aresetn, m_valid_reg, !m_frame_end_reg || m_row_end_reg)
    `ASSERT_NEXT(a_skip_keeps_position, aclk, aresetn, accept && skip, $stable(col_cnt_reg) && $stable(row_cnt_reg))
    `ASSERT_NEXT(a_work_fills_stage, aclk, aresetn, work, s1_valid_reg)
    `ASSERT_NEXT(a_first_row_silent, aclk, aresetn, work && (row_cnt_reg == '0), !s1_emit_reg)

endmodule
